// ----- design/hexmix_pkg.sv -----
// Shared types, constants and register codes for the hexacopter motor mixer.
package hexmix_pkg;

   // Field widths
   localparam int THR_W  = 12;
   localparam int TERM_W = 16;
   localparam int ROLL_W = TERM_W + 1;
   localparam int SEQ_W  = 11;
   localparam int CSR_INDEX_W = 2;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Motors on the frame
   localparam int MOTOR_COUNT = 6;

   // Mixing weights in Q16
   localparam logic [15:0] W_HALF_SHIFT = 16'd15;
   localparam logic [15:0] W_SIN60      = 16'd56753;

   // Test sequence thresholds
   localparam logic [THR_W-1:0] CLEAR_LIMIT = 12'd1300;
   localparam logic [THR_W-1:0] WIN_LO      = 12'd1400;
   localparam logic [THR_W-1:0] WIN_HI      = 12'd1600;
   localparam logic [SEQ_W-1:0] STAGE_A_END = 11'd400;
   localparam logic [SEQ_W-1:0] STAGE_B_END = 11'd1200;
   localparam logic [SEQ_W-1:0] STAGE_C_END = 11'd1500;
   localparam logic [SEQ_W-1:0] ROLL_SPLIT  = 11'd700;
   localparam logic [SEQ_W-1:0] THR_SPLIT   = 11'd1300;
   localparam logic signed [ROLL_W-1:0] ROLL_UP   = 17'sd100;
   localparam logic signed [ROLL_W-1:0] ROLL_DOWN = 17'sd150;

   // Throttle overrides and idle command
   localparam logic [THR_W-1:0] TEST_THR = 12'd1500;
   localparam logic [THR_W-1:0] THR_LOW  = 12'd1200;
   localparam logic [THR_W-1:0] THR_MID  = 12'd1270;
   localparam logic [THR_W-1:0] IDLE_CMD = 12'd800;

   // Register reset values
   localparam logic [THR_W-1:0] MAX_THROTTLE_RST    = 12'd2000;
   localparam logic [THR_W-1:0] MIN_THROTTLE_RST    = 12'd1100;
   localparam logic [THR_W-1:0] STICK_MIN_CHECK_RST = 12'd1100;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_THROTTLE    = 2'd0,
      CSR_MIN_THROTTLE    = 2'd1,
      CSR_STICK_MIN_CHECK = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [THR_W-1:0]         throttle_cmd;
      logic signed [TERM_W-1:0] roll_term;
      logic signed [TERM_W-1:0] pitch_term;
      logic signed [TERM_W-1:0] yaw_term;
      logic [THR_W-1:0]         aux_channel;
      logic [THR_W-1:0]         throttle_stick;
      logic                     armed;
      logic                     alt_hold;
   } req_type;

   typedef struct packed {
      logic [THR_W-1:0] motor_0;
      logic [THR_W-1:0] motor_1;
      logic [THR_W-1:0] motor_2;
      logic [THR_W-1:0] motor_3;
      logic [THR_W-1:0] motor_4;
      logic [THR_W-1:0] motor_5;
   } rsp_type;

   // Classified command handed from front to back
   typedef struct packed {
      logic [THR_W-1:0]         thr;
      logic signed [ROLL_W-1:0] roll;
      logic signed [TERM_W-1:0] pitch;
      logic signed [TERM_W-1:0] yaw;
      logic                     idle;
   } cmd_type;

   typedef struct packed {
      logic [THR_W-1:0] max_throttle;
      logic [THR_W-1:0] min_throttle;
      logic [THR_W-1:0] stick_min_check;
   } cfg_type;

endpackage

// ----- design/hexmix_front.sv -----
// Front end: test sequence counter, throttle override, roll bias and idle decision.
module hexmix_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  hexmix_pkg::req_type req_payload,
   input  hexmix_pkg::cfg_type cfg,
   output hexmix_pkg::cmd_type cmd
);

   logic [hexmix_pkg::SEQ_W-1:0] seq_count_ff;
   logic [hexmix_pkg::SEQ_W-1:0] seq_count_in;

   logic                                   win;
   logic [hexmix_pkg::THR_W-1:0]           thr;
   logic signed [hexmix_pkg::ROLL_W-1:0]   roll;

   // Run the sequence checks in order; each may feed the next
   always_comb begin
      win = (req_payload.aux_channel > hexmix_pkg::WIN_LO) &&
            (req_payload.aux_channel < hexmix_pkg::WIN_HI);
      seq_count_in = seq_count_ff;
      thr  = req_payload.throttle_cmd;
      roll = hexmix_pkg::ROLL_W'(req_payload.roll_term);

      if ((req_payload.aux_channel != '0) &&
          (req_payload.aux_channel < hexmix_pkg::CLEAR_LIMIT)) begin
         seq_count_in = '0;
      end
      if ((seq_count_in <= hexmix_pkg::STAGE_A_END) && win) begin
         seq_count_in = seq_count_in + 1'b1;
         thr = hexmix_pkg::TEST_THR;
      end
      if ((seq_count_in > hexmix_pkg::STAGE_A_END) &&
          (seq_count_in <= hexmix_pkg::STAGE_B_END) && win) begin
         seq_count_in = seq_count_in + 1'b1;
         thr = hexmix_pkg::TEST_THR;
         if (seq_count_in < hexmix_pkg::ROLL_SPLIT) begin
            roll = roll + hexmix_pkg::ROLL_UP;
         end else begin
            roll = roll - hexmix_pkg::ROLL_DOWN;
         end
      end
      if ((seq_count_in > hexmix_pkg::STAGE_B_END) &&
          (seq_count_in <= hexmix_pkg::STAGE_C_END) && win) begin
         seq_count_in = seq_count_in + 1'b1;
         if (seq_count_in <= hexmix_pkg::THR_SPLIT) begin
            thr = hexmix_pkg::THR_LOW;
         end else if (seq_count_in <= hexmix_pkg::STAGE_C_END) begin
            thr = hexmix_pkg::THR_MID;
         end
      end
   end

   // Build the command for the back end
   always_comb begin
      cmd.thr   = thr;
      cmd.roll  = roll;
      cmd.pitch = req_payload.pitch_term;
      cmd.yaw   = req_payload.yaw_term;
      cmd.idle  = !req_payload.armed ||
                  (!req_payload.alt_hold &&
                   (req_payload.throttle_stick < cfg.stick_min_check));
   end

   // Advance the counter on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_count_ff <= '0;
      end else if (accept) begin
         seq_count_ff <= seq_count_in;
      end
   end

endmodule

// ----- design/hexmix_queue.sv -----
// Short command queue between the front and back ends.
module hexmix_queue #(
   parameter int DEPTH = hexmix_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hexmix_pkg::cmd_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output hexmix_pkg::cmd_type pop_data
);

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   hexmix_pkg::cmd_type entry_ff [DEPTH];

   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == COUNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   // Store the entry at the write pointer
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Move the pointers and the fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- design/hexmix_back.sv -----
// Back end: Q16 mixing, overshoot shift, clamp and idle override over four stages.
module hexmix_back (
   input  logic                clock,
   input  logic                reset,
   input  hexmix_pkg::cfg_type cfg,
   input  logic                cmd_valid,
   input  hexmix_pkg::cmd_type cmd,
   output logic                cmd_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hexmix_pkg::rsp_type rsp_payload
);

   localparam int SW = 40;
   localparam int MW = 20;
   localparam int PW = hexmix_pkg::TERM_W + 17;
   localparam int NM = hexmix_pkg::MOTOR_COUNT;

   // Truncate a Q16 value toward zero
   function automatic logic signed [MW-1:0] trunc_q16(input logic signed [SW-1:0] s);
      logic signed [SW-1:0] q;
      q = s >>> 16;
      if (s[SW-1] && (s[15:0] != '0)) begin
         q = q + 1'b1;
      end
      return MW'(q);
   endfunction

   logic en;

   // Stage 1 registers
   logic                s1_valid_ff;
   hexmix_pkg::cmd_type s1_cmd_ff;
   logic signed [PW-1:0] s1_prod_ff;
   logic signed [PW-1:0] s1_prod_in;

   // Stage 2 registers
   logic                 s2_valid_ff;
   logic                 s2_idle_ff;
   logic signed [MW-1:0] s2_m_ff [NM];
   logic signed [MW-1:0] s2_m_in [NM];

   // Stage 3 registers
   logic                 s3_valid_ff;
   logic                 s3_idle_ff;
   logic signed [MW-1:0] s3_m_ff [NM];
   logic signed [MW-1:0] s3_top_ff;
   logic signed [MW-1:0] s3_top_in;

   // Output registers
   logic                rsp_valid_ff;
   hexmix_pkg::rsp_type rsp_payload_ff;
   logic [hexmix_pkg::THR_W-1:0] motor_in [NM];

   // Hold everything while a result waits
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign cmd_pop   = en && cmd_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Stage 1: pitch times sin 60 in Q16
   assign s1_prod_in = cmd.pitch * $signed({1'b0, hexmix_pkg::W_SIN60});

   // Stage 2: weighted sums
   always_comb begin
      logic signed [MW-1:0] ti;
      logic signed [MW-1:0] ri;
      logic signed [MW-1:0] yi;
      logic signed [SW-1:0] int_p;
      logic signed [SW-1:0] int_m;
      logic signed [SW-1:0] half;
      logic signed [SW-1:0] prod;
      ti    = MW'(signed'({1'b0, s1_cmd_ff.thr}));
      ri    = MW'(s1_cmd_ff.roll);
      yi    = MW'(s1_cmd_ff.yaw);
      int_p = SW'(ti + yi) <<< 16;
      int_m = SW'(ti - yi) <<< 16;
      half  = SW'(s1_cmd_ff.roll) <<< hexmix_pkg::W_HALF_SHIFT;
      prod  = SW'(s1_prod_ff);
      s2_m_in[0] = trunc_q16(int_m + half + prod);
      s2_m_in[1] = trunc_q16(int_p - half - prod);
      s2_m_in[2] = trunc_q16(int_p - half + prod);
      s2_m_in[3] = trunc_q16(int_m + half - prod);
      s2_m_in[4] = ti + ri + yi;
      s2_m_in[5] = ti - ri - yi;
   end

   // Stage 3: largest motor through a small tree
   always_comb begin
      logic signed [MW-1:0] a;
      logic signed [MW-1:0] b;
      logic signed [MW-1:0] c;
      logic signed [MW-1:0] d;
      a = (s2_m_ff[1] > s2_m_ff[0]) ? s2_m_ff[1] : s2_m_ff[0];
      b = (s2_m_ff[3] > s2_m_ff[2]) ? s2_m_ff[3] : s2_m_ff[2];
      c = (s2_m_ff[5] > s2_m_ff[4]) ? s2_m_ff[5] : s2_m_ff[4];
      d = (b > a) ? b : a;
      s3_top_in = (c > d) ? c : d;
   end

   // Stage 4: shift down on overshoot, clamp, idle override
   always_comb begin
      logic signed [MW-1:0] hi;
      logic signed [MW-1:0] lo;
      logic signed [MW-1:0] v;
      hi = MW'(signed'({1'b0, cfg.max_throttle}));
      lo = MW'(signed'({1'b0, cfg.min_throttle}));
      for (int i = 0; i < NM; i++) begin
         v = s3_m_ff[i];
         if (s3_top_ff > hi) begin
            v = v - (s3_top_ff - hi);
         end
         if (v < lo) begin
            v = lo;
         end else if (v > hi) begin
            v = hi;
         end
         motor_in[i] = s3_idle_ff ? hexmix_pkg::IDLE_CMD : v[hexmix_pkg::THR_W-1:0];
      end
   end

   // Advance the payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         s1_cmd_ff  <= cmd;
         s1_prod_ff <= s1_prod_in;
         s2_idle_ff <= s1_cmd_ff.idle;
         s2_m_ff    <= s2_m_in;
         s3_idle_ff <= s2_idle_ff;
         s3_m_ff    <= s2_m_ff;
         s3_top_ff  <= s3_top_in;
         rsp_payload_ff.motor_0 <= motor_in[0];
         rsp_payload_ff.motor_1 <= motor_in[1];
         rsp_payload_ff.motor_2 <= motor_in[2];
         rsp_payload_ff.motor_3 <= motor_in[3];
         rsp_payload_ff.motor_4 <= motor_in[4];
         rsp_payload_ff.motor_5 <= motor_in[5];
      end
   end

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= cmd_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

endmodule

// ----- design/hexacopter_motor_mixer_core.sv -----
// An input transfer is written into the queue, then passes through back stages one to three
// and the output register before rsp_valid rises; a stalled output holds it on the way.
// Throughput: one item per cycle while the queue has room; the front counter updates in
// the accept cycle and the back pipeline advances as a whole whenever the output register
// is free or taken. The two-entry queue lets the front keep accepting while a result waits.
// Reset is synchronous, active high: clears the sequence count, queue and valid bits, and
// loads max_throttle 2000, min_throttle 1100, stick_min_check 1100.
module hexacopter_motor_mixer_core #(
   parameter int QUEUE_DEPTH = hexmix_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  hexmix_pkg::req_type                  req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output hexmix_pkg::rsp_type                  rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hexmix_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [hexmix_pkg::THR_W-1:0]         csr_data
);

   hexmix_pkg::cfg_type cfg_ff;
   hexmix_pkg::cmd_type front_cmd;
   hexmix_pkg::cmd_type queue_cmd;
   logic                queue_full;
   logic                queue_valid;
   logic                queue_pop;
   logic                req_accept;

   assign csr_ready  = 1'b1;
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !queue_full;

   // Write the configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_throttle    <= hexmix_pkg::MAX_THROTTLE_RST;
         cfg_ff.min_throttle    <= hexmix_pkg::MIN_THROTTLE_RST;
         cfg_ff.stick_min_check <= hexmix_pkg::STICK_MIN_CHECK_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            hexmix_pkg::CSR_MAX_THROTTLE:    cfg_ff.max_throttle    <= csr_data;
            hexmix_pkg::CSR_MIN_THROTTLE:    cfg_ff.min_throttle    <= csr_data;
            hexmix_pkg::CSR_STICK_MIN_CHECK: cfg_ff.stick_min_check <= csr_data;
            default: ;
         endcase
      end
   end

   hexmix_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .cmd         (front_cmd)
   );

   hexmix_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (front_cmd),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_valid),
      .pop_data  (queue_cmd)
   );

   hexmix_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cmd_valid   (queue_valid),
      .cmd         (queue_cmd),
      .cmd_pop     (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- tb/hexacopter_motor_mixer_core_test.sv -----
// Self-checking testbench for the hexacopter motor mixer core.
`timescale 1ns / 1ps

module hexacopter_motor_mixer_core_test;

   localparam int CLOCK_PERIOD    = 20;
   localparam int RESET_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int SETTLE_CYCLES   = 12;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int REPORT_LIMIT    = 100;

   // Mixing weights in Q16
   localparam longint Q16_ONE   = 65536;
   localparam longint Q16_HALF  = 32768;
   localparam longint Q16_SIN60 = 56753;

   // Test sequence windows and overrides
   localparam int     AUX_CLEAR_BELOW = 1300;
   localparam int     AUX_WIN_LO      = 1400;
   localparam int     AUX_WIN_HI      = 1600;
   localparam int     SEQ_A_END       = 400;
   localparam int     SEQ_B_END       = 1200;
   localparam int     SEQ_C_END       = 1500;
   localparam int     SEQ_ROLL_SPLIT  = 700;
   localparam int     SEQ_THR_SPLIT   = 1300;
   localparam int     SEQ_WALK_TOP    = 450;
   localparam longint SEQ_THR_TEST    = 1500;
   localparam longint SEQ_THR_LOW     = 1200;
   localparam longint SEQ_THR_MID     = 1270;
   localparam longint ROLL_BIAS_UP    = 100;
   localparam longint ROLL_BIAS_DOWN  = 150;
   localparam longint IDLE_MOTOR      = 800;

   localparam int THR_W       = hexmix_pkg::THR_W;
   localparam int TERM_W      = hexmix_pkg::TERM_W;
   localparam int CSR_INDEX_W = hexmix_pkg::CSR_INDEX_W;
   localparam int MOTOR_COUNT = hexmix_pkg::MOTOR_COUNT;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   hexmix_pkg::req_type    req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   hexmix_pkg::rsp_type    rsp_payload;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [THR_W-1:0]       csr_data    = '0;

   // Predictor copy of the limits and the test sequence count
   logic [THR_W-1:0] max_thr   = hexmix_pkg::MAX_THROTTLE_RST;
   logic [THR_W-1:0] min_thr   = hexmix_pkg::MIN_THROTTLE_RST;
   logic [THR_W-1:0] stick_min = hexmix_pkg::STICK_MIN_CHECK_RST;
   int               seq_count = 0;
   int               seq_peak  = 0;

   hexmix_pkg::rsp_type expected_motors[$];
   int      errors          = 0;
   int      items_sent      = 0;
   int      results_checked = 0;
   int      csr_writes      = 0;
   int      quiet_cycles    = 0;
   int      req_idle_pct    = 30;
   int      rsp_idle_pct    = 30;
   int      hold_request    = 0;
   bit      req_up          = 1'b0;

   hexacopter_motor_mixer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // One weighted sum in Q16, truncated toward zero
   function automatic longint mix_q16(longint thr, longint roll, longint pitch, longint yaw,
                                      longint w_roll, longint w_pitch, longint w_yaw);
      longint acc;
      acc = thr * Q16_ONE + w_roll * roll + w_pitch * pitch + w_yaw * yaw * Q16_ONE;
      return acc / Q16_ONE;
   endfunction

   // Advance the test sequence and work out the six motor commands
   function automatic hexmix_pkg::rsp_type predict_motors(hexmix_pkg::req_type item);
      longint  thr, roll, pitch, yaw, top, hi, lo;
      longint  m [MOTOR_COUNT];
      int      aux, cnt;
      bit      in_window;
      hexmix_pkg::rsp_type res;
      thr       = longint'(item.throttle_cmd);
      roll      = longint'($signed(item.roll_term));
      pitch     = longint'($signed(item.pitch_term));
      yaw       = longint'($signed(item.yaw_term));
      aux       = int'(item.aux_channel);
      in_window = aux > AUX_WIN_LO && aux < AUX_WIN_HI;
      cnt       = seq_count;

      // Chained stages: a stage that moves the count on lets the next one run too
      if (aux > 0 && aux < AUX_CLEAR_BELOW) cnt = 0;
      if (cnt <= SEQ_A_END && in_window) begin
         cnt++;
         thr = SEQ_THR_TEST;
      end
      if (cnt > SEQ_A_END && cnt <= SEQ_B_END && in_window) begin
         cnt++;
         thr = SEQ_THR_TEST;
         roll += (cnt < SEQ_ROLL_SPLIT) ? ROLL_BIAS_UP : -ROLL_BIAS_DOWN;
      end
      if (cnt > SEQ_B_END && cnt <= SEQ_C_END && in_window) begin
         cnt++;
         if (cnt <= SEQ_THR_SPLIT) thr = SEQ_THR_LOW;
         else if (cnt <= SEQ_C_END) thr = SEQ_THR_MID;
      end
      seq_count = cnt;

      // X-frame mix
      m[2] = mix_q16(thr, roll, pitch, yaw, -Q16_HALF,  Q16_SIN60,  1);
      m[1] = mix_q16(thr, roll, pitch, yaw, -Q16_HALF, -Q16_SIN60,  1);
      m[0] = mix_q16(thr, roll, pitch, yaw,  Q16_HALF,  Q16_SIN60, -1);
      m[3] = mix_q16(thr, roll, pitch, yaw,  Q16_HALF, -Q16_SIN60, -1);
      m[5] = thr - roll - yaw;
      m[4] = thr + roll + yaw;

      // Shift down on overshoot, then clamp with the floor tested first
      hi  = longint'(max_thr);
      lo  = longint'(min_thr);
      top = m[0];
      for (int i = 1; i < MOTOR_COUNT; i++) if (m[i] > top) top = m[i];
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         if (top > hi) m[i] -= top - hi;
         if (m[i] < lo) m[i] = lo;
         else if (m[i] > hi) m[i] = hi;
      end

      // Idle when disarmed, or stick low without altitude hold
      if (!item.armed || (!item.alt_hold && item.throttle_stick < stick_min))
         for (int i = 0; i < MOTOR_COUNT; i++) m[i] = IDLE_MOTOR;

      res.motor_0 = THR_W'(m[0]);
      res.motor_1 = THR_W'(m[1]);
      res.motor_2 = THR_W'(m[2]);
      res.motor_3 = THR_W'(m[3]);
      res.motor_4 = THR_W'(m[4]);
      res.motor_5 = THR_W'(m[5]);
      return res;
   endfunction

   function automatic hexmix_pkg::req_type item_of(int thr, int roll, int pitch, int yaw,
                                                   int aux, int stick, bit armed,
                                                   bit alt_hold);
      hexmix_pkg::req_type item;
      item.throttle_cmd   = THR_W'(thr);
      item.roll_term      = TERM_W'(roll);
      item.pitch_term     = TERM_W'(pitch);
      item.yaw_term       = TERM_W'(yaw);
      item.aux_channel    = THR_W'(aux);
      item.throttle_stick = THR_W'(stick);
      item.armed          = armed;
      item.alt_hold       = alt_hold;
      return item;
   endfunction

   // Mostly modest corrections, now and then the full range
   function automatic logic [TERM_W-1:0] random_term();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) return TERM_W'(int'($urandom_range(1600)) - 800);
      if (pick < 90) return TERM_W'(int'($urandom_range(8000)) - 4000);
      return TERM_W'($urandom);
   endfunction

   // Aux value: in window, or else one that holds the count (or anything when clears are allowed)
   function automatic logic [THR_W-1:0] pick_aux(int window_pct, bit allow_clear);
      int pick;
      pick = $urandom_range(99);
      if (pick < window_pct) return THR_W'($urandom_range(AUX_WIN_LO + 1, AUX_WIN_HI - 1));
      if (allow_clear && pick[0]) return THR_W'($urandom);
      case ($urandom_range(2))
         0: return '0;
         1: return THR_W'($urandom_range(AUX_CLEAR_BELOW, AUX_WIN_LO));
         default: return THR_W'($urandom_range(AUX_WIN_HI, 4095));
      endcase
   endfunction

   function automatic hexmix_pkg::req_type random_item(logic [THR_W-1:0] aux);
      hexmix_pkg::req_type item;
      item.throttle_cmd   = ($urandom_range(99) < 60) ? THR_W'($urandom_range(900, 2100))
                                                      : THR_W'($urandom);
      item.roll_term      = random_term();
      item.pitch_term     = random_term();
      item.yaw_term       = random_term();
      item.aux_channel    = aux;
      item.throttle_stick = ($urandom_range(99) < 50) ? THR_W'($urandom_range(900, 1300))
                                                      : THR_W'($urandom);
      item.armed          = $urandom_range(99) < 90;
      item.alt_hold       = 1'($urandom_range(1));
      return item;
   endfunction

   // Offer one item, hold it until the transfer, then record the expected motors
   task automatic send_item(hexmix_pkg::req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         if (req_up) begin
            req_valid <= 1'b0;
            req_up = 1'b0;
         end
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_up       = 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      expected_motors.push_back(predict_motors(item));
      items_sent++;
      if (seq_count > seq_peak) seq_peak = seq_count;
   endtask

   task automatic run_random(int count, int window_pct, bit allow_clear);
      repeat (count) send_item(random_item(pick_aux(window_pct, allow_clear)));
   endtask

   // Stop offering and wait for every outstanding result
   task automatic wait_all_motors();
      if (req_up) begin
         req_valid <= 1'b0;
         req_up = 1'b0;
      end
      while (expected_motors.size() != 0) @(posedge clock);
   endtask

   // Leaves csr_valid high so back-to-back writes need no gap
   task automatic write_reg(hexmix_pkg::csr_index_type idx, logic [THR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         hexmix_pkg::CSR_MAX_THROTTLE:    max_thr   = value;
         hexmix_pkg::CSR_MIN_THROTTLE:    min_thr   = value;
         hexmix_pkg::CSR_STICK_MIN_CHECK: stick_min = value;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic set_limits(int ceiling, int floor_level, int stick_level);
      wait_all_motors();
      write_reg(hexmix_pkg::CSR_MAX_THROTTLE, THR_W'(ceiling));
      write_reg(hexmix_pkg::CSR_MIN_THROTTLE, THR_W'(floor_level));
      write_reg(hexmix_pkg::CSR_STICK_MIN_CHECK, THR_W'(stick_level));
      csr_valid <= 1'b0;
   endtask

   // Field extremes, idle rules, clamps and the sequence windows at reset limits
   task automatic test_corner_items();
      send_item(item_of(0, 0, 0, 0, 0, 0, 0, 0));
      send_item(item_of(4095, 32767, -32768, 32767, 4095, 4095, 1, 1));
      send_item(item_of(4095, -32768, 32767, -32768, 0, 4095, 1, 0));
      send_item(item_of(1500, 0, 0, 0, 1000, 1500, 1, 0));
      send_item(item_of(1500, 300, -200, 50, 0, 1500, 1, 0));
      send_item(item_of(1000, 40, 30, -20, 0, 1500, 1, 1));
      send_item(item_of(1990, 200, 150, 40, 0, 1500, 1, 1));
      send_item(item_of(1500, 300, 0, 0, 0, 1099, 1, 0));
      send_item(item_of(1500, 300, 0, 0, 0, 1100, 1, 0));
      send_item(item_of(1500, 300, 0, 0, 0, 0, 1, 1));
      send_item(item_of(1500, 300, 0, 0, 0, 4095, 0, 1));
      send_item(item_of(1300, -1, -1, 0, 0, 1500, 1, 1));
      send_item(item_of(1300, 1, 1, 0, 0, 1500, 1, 1));
      send_item(item_of(1400, -3, 7, -500, 0, 1500, 1, 1));
      // Sequence: enter the window, hold outside it, clear and hold at the edges
      send_item(item_of(1000, 20, -20, 5, 1401, 1500, 1, 1));
      send_item(item_of(1000, 20, -20, 5, 1599, 1500, 1, 1));
      send_item(item_of(1000, 20, -20, 5, 1400, 1500, 1, 1));
      send_item(item_of(1000, 20, -20, 5, 1600, 1500, 1, 1));
      send_item(item_of(1000, 20, -20, 5, 1300, 1500, 1, 1));
      send_item(item_of(1000, 20, -20, 5, 1500, 1500, 0, 0));
      send_item(item_of(1000, 20, -20, 5, 1299, 1500, 1, 1));
      send_item(item_of(1000, 20, -20, 5, 1, 1500, 1, 1));
   endtask

   // Register extremes, including a floor above the ceiling
   task automatic test_limit_settings();
      set_limits(4095, 0, 0);
      run_random(8, 30, 1);
      set_limits(0, 4095, 4095);
      run_random(8, 30, 1);
      set_limits(4095, 4095, 0);
      run_random(8, 30, 1);
      set_limits(0, 0, 4095);
      run_random(8, 30, 1);
      set_limits(1200, 1800, 1000);
      run_random(8, 30, 1);
      set_limits(hexmix_pkg::MAX_THROTTLE_RST, hexmix_pkg::MIN_THROTTLE_RST,
                 hexmix_pkg::STICK_MIN_CHECK_RST);
   endtask

   // Hold the result side off while items keep coming, then pause until all are back
   task automatic test_back_pressure();
      req_idle_pct = 0;
      hold_request = HOLD_OFF_CYCLES;
      run_random(30, 30, 1);
      wait_all_motors();
      req_idle_pct = 30;
   endtask

   // Walk the count through stage A and on into stage B
   task automatic test_sequence_walk();
      int walk_start;
      walk_start   = items_sent;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_item(random_item(THR_W'(AUX_CLEAR_BELOW - 300)));
      while (seq_count < SEQ_WALK_TOP) begin
         if (items_sent - walk_start == 400) begin
            req_idle_pct = 30;
            rsp_idle_pct = 30;
         end
         send_item(random_item(pick_aux(95, 0)));
      end
      req_idle_pct = 30;
      rsp_idle_pct = 30;
      run_random(10, 88, 0);
   endtask

   // Free mix with clears, under changing limits
   task automatic test_random_mix();
      for (int phase = 0; phase < 4; phase++) begin
         if (phase[0])
            set_limits($urandom_range(4095), $urandom_range(4095), $urandom_range(4095));
         else
            set_limits($urandom_range(1700, 2100), $urandom_range(900, 1200),
                       $urandom_range(1000, 1200));
         run_random(10, 35, 1);
      end
   endtask

   // Result side: random stalls, and long hold-offs on request
   initial begin : result_sink
      int left;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            left = hold_request;
            hold_request = 0;
            while (left > 0) begin
               rsp_stall <= 1'b1;
               left--;
               @(posedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      hexmix_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_motors.size() == 0) begin
            if (errors < REPORT_LIMIT)
               $display("%0t: result with nothing expected, actual %h", $time, rsp_payload);
            errors++;
         end else begin
            want = expected_motors.pop_front();
            results_checked++;
            for (int i = 0; i < MOTOR_COUNT; i++) begin
               if (want[(MOTOR_COUNT-1-i)*THR_W +: THR_W] !=
                   rsp_payload[(MOTOR_COUNT-1-i)*THR_W +: THR_W]) begin
                  if (errors < REPORT_LIMIT)
                     $display("%0t: motor_%0d expected %0d actual %0d", $time, i,
                              want[(MOTOR_COUNT-1-i)*THR_W +: THR_W],
                              rsp_payload[(MOTOR_COUNT-1-i)*THR_W +: THR_W]);
                  errors++;
               end
            end
         end
      end
   end

   // Abort when nothing transfers on any channel for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_corner_items();
      test_limit_settings();
      test_back_pressure();
      test_sequence_walk();
      test_random_mix();
      wait_all_motors();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d control ticks, checked %0d motor results, %0d register writes.",
               items_sent, results_checked, csr_writes);
      $display("Test sequence count reached %0d; result side held off for %0d cycles once.",
               seq_peak, HOLD_OFF_CYCLES);
      if (errors == 0 && expected_motors.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- hexacopter_motor_mixer_core.f -----
design/hexmix_pkg.sv
design/hexmix_front.sv
design/hexmix_queue.sv
design/hexmix_back.sv
design/hexacopter_motor_mixer_core.sv
tb/hexacopter_motor_mixer_core_test.sv
